### rtl/double_ended_queue_unit_defines.svh
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while rst_sig is high.
`define DEQ_ASSERT_NOW(label, clk_sig, rst_sig, lhs, rhs) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (lhs) |-> (rhs)) \
    else $error("deque check failed");

// Next-cycle implication, disabled while rst_sig is high.
`define DEQ_ASSERT_NEXT(label, clk_sig, rst_sig, lhs, rhs) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (lhs) |=> (rhs)) \
    else $error("deque check failed");

`endif

### rtl/deq_pkg.sv
// Shared types, constants and index helpers of the deque unit.
package deq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_M1 = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    logic    push_front;
    logic    push_rear;
    logic    pop_front;
    logic    pop_rear;
    logic    dump_start;
    logic    rd_issue;
    logic    load_status;
    logic    load_rd;
    status_t status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic rd_done;
    logic rd_last;
  } dp_status_t;

  // Reduce front + offset (offset below DEPTH) into a slot index.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] sum);
    logic [IDX_W:0] d;
    d = (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
    return d[IDX_W-1:0];
  endfunction

endpackage

### rtl/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue unit.
//
//   channel   signals                         contents
//   s_axis    tvalid tready tdata tuser       command and push value
//   m_axis    tvalid tready tdata tuser tlast result value, status, last mark
//
// Push and pop each give one result through the output register.
// A dump of N > 0 values gives N results, one per cycle while m_axis_tready is high,
// through the store's single registered read port; no input is taken then.
// Reset clears the pointers, counts and control state; the store is not cleared.
// A low m_axis_tready holds a valid output register; s_axis_tready then drops with it.
module double_ended_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value_in
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_out
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);
  import deq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_cmd    (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value_in   (s_axis_tdata),
    .stat       (stat),
    .value_out  (m_axis_tdata),
    .status_out (m_axis_tuser),
    .last_out   (m_axis_tlast)
  );

endmodule

### rtl/deq_datapath.sv
// Deque datapath: circular store, front and count, dump reader, output register.
module deq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  deq_pkg::ctrl_cmd_t            cmd,
  input  logic [31:0]                   value_in,
  output deq_pkg::dp_status_t           stat,
  output logic [31:0]                   value_out,
  output logic [1:0]                    status_out,
  output logic                          last_out
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]  front;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  rd_left;
  logic [DATA_W-1:0] rd_data;
  logic              rd_last;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  rear_slot;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  assign front_dec = (front == '0) ? DEPTH_M1 : (front - IDX_W'(1));
  assign rear_slot = wrap_idx({1'b0, front} + {1'b0, count[IDX_W-1:0]});
  assign wr_en     = cmd.push_front | cmd.push_rear;
  assign wr_addr   = cmd.push_front ? front_dec : rear_slot;

  assign stat.full    = (count == DEPTH_C);
  assign stat.empty   = (count == '0);
  assign stat.rd_done = (rd_left == '0);
  assign stat.rd_last = rd_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_in;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_ptr];
      rd_last <= (rd_left == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      count   <= '0;
      rd_ptr  <= '0;
      rd_left <= '0;
    end else begin
      if (cmd.push_front) begin
        front <= front_dec;
        count <= count + CNT_W'(1);
      end else if (cmd.push_rear) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop_front) begin
        front <= wrap_idx({1'b0, front} + (IDX_W + 1)'(1));
        count <= count - CNT_W'(1);
      end else if (cmd.pop_rear) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.dump_start) begin
        rd_ptr  <= front;
        rd_left <= count;
      end else if (cmd.rd_issue) begin
        rd_ptr  <= wrap_idx({1'b0, rd_ptr} + (IDX_W + 1)'(1));
        rd_left <= rd_left - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      value_out  <= '0;
      status_out <= cmd.status;
      last_out   <= 1'b1;
    end else if (cmd.load_rd) begin
      value_out  <= rd_data;
      status_out <= ST_OK;
      last_out   <= rd_last;
    end
  end

endmodule

### rtl/deq_ctrl.sv
// Deque controller: command decode, dump sequencing, output handshake.
module deq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [2:0]           in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  deq_pkg::dp_status_t  stat,
  output deq_pkg::ctrl_cmd_t   cmd
);
  import deq_pkg::*;

  state_t state;
  state_t state_next;
  logic   rd_valid;
  logic   rd_valid_next;
  logic   out_valid_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    accept   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = out_free;
        accept   = in_valid && out_free;
        if (accept) begin
          case (in_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              cmd.load_status = 1'b1;
              cmd.status      = stat.full ? ST_OVER : ST_OK;
              cmd.push_front  = !stat.full && (in_cmd == CMD_PUSH_FRONT);
              cmd.push_rear   = !stat.full && (in_cmd == CMD_PUSH_REAR);
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
              cmd.load_status = 1'b1;
              cmd.status      = stat.empty ? ST_UNDER : ST_OK;
              cmd.pop_front   = !stat.empty && (in_cmd == CMD_POP_FRONT);
              cmd.pop_rear    = !stat.empty && (in_cmd == CMD_POP_REAR);
            end
            CMD_DUMP: begin
              cmd.load_status = stat.empty;
              cmd.status      = ST_EMPTY;
              cmd.dump_start  = !stat.empty;
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        cmd.load_rd  = rd_valid && out_free;
        cmd.rd_issue = !stat.rd_done && (!rd_valid || cmd.load_rd);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.dump_start) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (cmd.load_rd && stat.rd_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.rd_issue) begin
      rd_valid_next = 1'b1;
    end else if (cmd.load_rd) begin
      rd_valid_next = 1'b0;
    end else begin
      rd_valid_next = rd_valid;
    end
    if (cmd.load_status || cmd.load_rd) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/deq_checker.sv
// Port-level checks of the deque unit and their binding to the top level.
`include "double_ended_queue_unit_defines.svh"

module deq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import deq_pkg::*;

  logic in_item;
  logic err_result;

  assign in_item    = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
  assign err_result = m_axis_tvalid && (m_axis_tuser != ST_OK);

  `DEQ_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `DEQ_ASSERT_NOW(a_err_is_last, clk, rst, err_result, m_axis_tlast && (m_axis_tdata == '0))
  `DEQ_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !m_axis_tvalid)
  `DEQ_ASSERT_NEXT(a_op_gives_result, clk, rst, in_item && (s_axis_tuser <= CMD_POP_REAR), m_axis_tvalid && m_axis_tlast)

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/tb_double_ended_queue_unit.sv
// Testbench for the double-ended queue unit: deque scoreboard, stream drivers and result checks.
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
  import deq_pkg::*;

  class deque_scoreboard;
    typedef struct {
      logic [DATA_W-1:0] value;
      status_t           status;
      logic              last;
    } deq_result_t;

    logic [DATA_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0]  head;
    logic [CNT_W-1:0]  count;
    deq_result_t       result_q[$];
    int                errors;

    function new();
      head = '0;
      count = '0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function int occupancy();
      return int'(count);
    endfunction

    function void add_result(logic [DATA_W-1:0] value, status_t status, logic last);
      deq_result_t r;
      r.value = value;
      r.status = status;
      r.last = last;
      result_q.push_back(r);
    endfunction

    // Advance the deque model by one accepted item and queue the results it causes.
    function void note_input(logic [2:0] cmd, logic [DATA_W-1:0] value);
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          if (count == DEPTH_C) begin
            add_result('0, ST_OVER, 1'b1);
          end else begin
            if (cmd == CMD_PUSH_FRONT) begin
              head = (head == '0) ? DEPTH_M1 : head - 1'b1;
              slots[head] = value;
            end else begin
              slots[(int'(head) + int'(count)) % DEPTH] = value;
            end
            count++;
            add_result('0, ST_OK, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          if (count == '0) begin
            add_result('0, ST_UNDER, 1'b1);
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              head = (head == DEPTH_M1) ? '0 : head + 1'b1;
            end
            count--;
            add_result('0, ST_OK, 1'b1);
          end
        end
        CMD_DUMP: begin
          if (count == '0) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < int'(count); i++) begin
              add_result(slots[(int'(head) + i) % DEPTH], ST_OK, i == int'(count) - 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) begin
        $display("deque mismatch: %s", msg);
      end
      errors++;
    endtask

    task check_result(logic [DATA_W-1:0] value, status_t status, logic last);
      deq_result_t want;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: value %h status %0d last %0b",
                                  value, status, last));
      end else begin
        want = result_q.pop_front();
        if (value !== want.value) begin
          report_mismatch($sformatf("value_out %h, want %h", value, want.value));
        end
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
      end
    endtask
  endclass

  localparam int MAX_GAP = 11;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 16;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_TARGET = 120;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic idle_en = 1'b1;
  logic sink_hold = 1'b0;
  int   cycle_count = 0;
  int   items_sent = 0;

  deque_scoreboard deq_sb;

  double_ended_queue_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap();
    return idle_en ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [31:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= value;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    deq_sb.note_input(cmd, value);
    items_sent++;
  endtask

  task automatic send_push();
    send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, $urandom());
  endtask

  task automatic send_pop();
    send_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom());
  endtask

  task automatic run_mixed(input int n, input int push_pct);
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom());
      end else if (roll < push_pct) begin
        send_push();
      end else if (roll < 90) begin
        send_pop();
      end else begin
        send_item(CMD_DUMP, $urandom());
      end
    end
  endtask

  task automatic fill_to_full();
    while (deq_sb.occupancy() < DEPTH) send_push();
    repeat (2) send_push();
    send_item(CMD_DUMP, $urandom());
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (deq_sb.pending() != 0);
  endtask

  initial begin : stimulus
    deq_sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_item(CMD_POP_REAR, 32'h0000_0000);
    send_item(CMD_DUMP, 32'h8000_0000);
    for (int code = CMD_UNUSED_LO; code <= CMD_UNUSED_HI; code++) begin
      send_item(3'(code), 32'h5A5A_A5A5);
    end
    send_item(CMD_PUSH_FRONT, 32'h8000_0000);
    send_item(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(CMD_PUSH_REAR, 32'h0000_0000);
    send_item(CMD_PUSH_FRONT, 32'h0000_0001);
    send_item(CMD_DUMP, 32'h0000_0000);
    send_item(CMD_POP_FRONT, 32'h0000_0000);
    send_item(CMD_POP_REAR, 32'h0000_0000);
    send_item(CMD_DUMP, 32'h0000_0000);
    repeat (3) send_item(CMD_POP_REAR, 32'h0000_0000);
    send_item(CMD_POP_FRONT, 32'h0000_0000);
    send_item(CMD_DUMP, 32'h0000_0000);

    run_mixed(20, 60);
    idle_en = 1'b0;
    fill_to_full();
    idle_en = 1'b1;
    sink_hold = 1'b1;
    run_mixed(12, 85);
    wait_drained();
    while (items_sent < RANDOM_TARGET) begin
      idle_en = ($urandom_range(0, 3) != 0);
      run_mixed($urandom_range(8, 20), $urandom_range(30, 80));
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (deq_sb.errors == 0 && deq_sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : result_sink
    int wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold) begin
        sink_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        wait_cycles = draw_gap();
        if (wait_cycles > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      deq_sb.check_result(m_axis_tdata, status_t'(m_axis_tuser), m_axis_tlast);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_datapath.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_unit.sv
rtl/deq_checker.sv
tb/sv/tb_double_ended_queue_unit.sv
